/* rtl/prts_pkg.sv */
// ----------------------------------------------------------------------------
// prts_pkg: shared types and codes for the remaining-time scheduler
// Event and state codes, the slot record that travels along the chain, the scan candidate, and widths.
// ----------------------------------------------------------------------------
package prts_pkg;

  localparam int IdW   = 8;
  localparam int TimeW = 16;
  localparam logic [TimeW-1:0] TimeMax = '1;

  // operation field of an input item
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_REJECTED = 3'd1,
    EV_IDLE     = 3'd2,
    EV_RAN      = 3'd3,
    EV_FINISHED = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_t;

  // best candidate seen so far as the scan passes down the chain
  typedef struct packed {
    logic             found;
    logic [IdW-1:0]   ident;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] left;
    logic [TimeW-1:0] first_run;
    logic             started;
  } cand_t;

  // one slot's view in the circulating chain
  typedef struct packed {
    logic             valid;
    logic             done;
    logic             started;
    logic [IdW-1:0]   ident;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] left;
    logic [TimeW-1:0] first_run;
  } slot_t;

endpackage

/* rtl/prts_cell.sv */
// ----------------------------------------------------------------------------
// prts_cell: one task slot in the circulating chain
// Holds one slot record and passes it to its neighbor when shift is high.
// ----------------------------------------------------------------------------
module prts_cell
  import prts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t din,
  output slot_t dout
);

  slot_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid   <= 1'b0;
      slot.done    <= 1'b0;
      slot.started <= 1'b0;
    end else if (shift) begin
      slot <= din;
    end
  end

  assign dout = slot;

endmodule

/* rtl/preemptive_remaining_time_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// preemptive_remaining_time_scheduler_unit: remaining-time task scheduler
// Task table in a ring of slot cells with a tick clock.
// ----------------------------------------------------------------------------
// The MAX_TASKS slots sit in a ring of cells that rotates one place a cycle
// while an item is scanned or applied. Every item, add or tick, takes one
// full turn of the ring to compare each slot at the ring head against the
// best candidate, a second full turn to rewrite the chosen slot as it passes
// the head, and then loads its result into the output register; the next
// item is taken only after that result is loaded. An add takes the first
// free slot in ring order, which is slot order because the ring always
// returns home. The output register holds a result until it is taken; the
// next item runs its two turns meanwhile and waits before loading its own
// result while the earlier one is still held.
module preemptive_remaining_time_scheduler_unit
  import prts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  input  logic [IdW-1:0]   task_id,
  input  logic [TimeW-1:0] arrival_time,
  input  logic [TimeW-1:0] burst_time,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       event_res,
  output logic [IdW-1:0]   running_id,
  output logic [TimeW-1:0] time_now,
  output logic [TimeW-1:0] turnaround,
  output logic [TimeW-1:0] waiting,
  output logic [TimeW-1:0] response
);

  localparam int PosW = $clog2(MAX_TASKS);

  state_t state, state_next;
  logic longest_mode;
  logic [TimeW-1:0] clock_count;
  logic op_r;
  logic [IdW-1:0] id_r;
  logic [TimeW-1:0] at_r, bt_r;
  logic [PosW-1:0] cnt;
  cand_t best;
  logic [PosW-1:0] best_pos, free_pos;
  logic free_found;
  logic shift;
  logic out_fire;

  slot_t ring [MAX_TASKS];
  slot_t head_new;

  // head of ring is cell 0; cell i feeds cell i-1, cell 0 wraps to last
  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cell
      slot_t din_g;
      if (g == MAX_TASKS - 1) begin : g_wrap
        assign din_g = head_new;
      end else begin : g_mid
        assign din_g = ring[g+1];
      end
      prts_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .din(din_g), .dout(ring[g]));
    end
  endgenerate

  slot_t head;
  assign head = ring[0];
  logic [PosW-1:0] pos;
  assign pos = cnt;

  logic is_tick;
  assign is_tick = (op_r == OP_TICK);

  logic elig, beats;
  always_comb begin
    elig = head.valid && !head.done && (head.left != '0) && (head.arrival <= clock_count);
    if (!best.found) beats = 1'b1;
    else if (head.left != best.left)
      beats = longest_mode ? (head.left > best.left) : (head.left < best.left);
    else if (head.arrival != best.arrival) beats = head.arrival < best.arrival;
    else beats = head.ident < best.ident;
  end

  // during the apply turn the chosen slot is rewritten as it passes the head
  logic apply_pass;
  logic add_ok;
  assign add_ok = free_found && (bt_r != '0);
  logic [TimeW-1:0] left_dec;
  assign left_dec = best.left - 1'b1;

  always_comb begin
    head_new = head;
    if (apply_pass && pos == (is_tick ? best_pos : free_pos)) begin
      if (!is_tick && add_ok) begin
        head_new.valid     = 1'b1;
        head_new.done      = 1'b0;
        head_new.started   = 1'b0;
        head_new.ident     = id_r;
        head_new.arrival   = at_r;
        head_new.burst     = bt_r;
        head_new.left      = bt_r;
        head_new.first_run = '0;
      end else if (is_tick && best.found) begin
        head_new.left = left_dec;
        if (!best.started) begin
          head_new.started   = 1'b1;
          head_new.first_run = clock_count;
        end
        if (left_dec == '0) head_new.done = 1'b1;
      end
    end
  end

  // scan turn and apply turn share the counter; ST_SCAN then ST_APPLY
  logic cnt_last;
  assign cnt_last = (cnt == PosW'(MAX_TASKS - 1));

  always_comb begin
    state_next = state;
    shift      = 1'b0;
    apply_pass = 1'b0;
    in_ready   = 1'b0;
    out_fire   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (cnt_last) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        shift      = 1'b1;
        apply_pass = 1'b1;
        if (cnt_last) state_next = ST_OUT;
      end
      // hold until the output register is free
      ST_OUT: begin
        out_fire = !out_valid || out_ready;
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) longest_mode <= 1'b0;
    else if (cfg_we) longest_mode <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE || cnt_last) cnt <= '0;
    else if (shift) cnt <= cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= operation;
      id_r <= task_id;
      at_r <= arrival_time;
      bt_r <= burst_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best.found <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_IDLE) begin
      best.found <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (elig && beats) begin
        best.found     <= 1'b1;
        best.ident     <= head.ident;
        best.arrival   <= head.arrival;
        best.burst     <= head.burst;
        best.left      <= head.left;
        best.first_run <= head.first_run;
        best.started   <= head.started;
        best_pos       <= pos;
      end
      if (!free_found && (!head.valid || head.done)) begin
        free_found <= 1'b1;
        free_pos   <= pos;
      end
    end
  end

  // result and clock update when the result is loaded in ST_OUT, after the apply turn
  logic [TimeW-1:0] clk_inc, tat, fr;
  assign clk_inc = (clock_count == TimeMax) ? clock_count : clock_count + 1'b1;
  assign tat = clk_inc - best.arrival;
  assign fr  = best.started ? best.first_run : clock_count;

  event_t           ev_next;
  logic [IdW-1:0]   id_next;
  logic [TimeW-1:0] tat_next, wt_next, rt_next;

  always_comb begin
    ev_next  = EV_RAN;
    id_next  = best.ident;
    tat_next = '0;
    wt_next  = '0;
    rt_next  = '0;
    if (!is_tick) begin
      ev_next = add_ok ? EV_ADDED : EV_REJECTED;
      id_next = id_r;
    end else if (!best.found) begin
      ev_next = EV_IDLE;
      id_next = '0;
    end else if (best.left == TimeW'(1)) begin
      ev_next  = EV_FINISHED;
      tat_next = tat;
      wt_next  = (tat >= best.burst) ? tat - best.burst : '0;
      rt_next  = fr - best.arrival;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_count <= '0;
      out_valid   <= 1'b0;
    end else if (out_fire) begin
      out_valid <= 1'b1;
      if (is_tick) clock_count <= clk_inc;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      event_res  <= ev_next;
      running_id <= id_next;
      time_now   <= is_tick ? clk_inc : clock_count;
      turnaround <= tat_next;
      waiting    <= wt_next;
      response   <= rt_next;
    end
  end

endmodule

/* rtl/prts_checker.sv */
// ----------------------------------------------------------------------------
// prts_checker: port-level checks for the scheduler
// Watches the handshakes and result codes, bound to the top level.
// ----------------------------------------------------------------------------
module prts_checker
  import prts_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       event_res,
  input logic [TimeW-1:0] time_now,
  input logic [TimeW-1:0] turnaround
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(time_now))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= EV_FINISHED)
    else $error("bad event code");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_tat: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_FINISHED |-> turnaround == '0)
    else $error("turnaround set without finish");

endmodule

bind preemptive_remaining_time_scheduler_unit prts_checker u_prts_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
  .time_now(time_now), .turnaround(turnaround)
);
